@@ hdl/icmp_echo_reply_classifier_core_assert.svh @@
// Assertion macros shared by the classifier RTL.
`ifndef ICMP_ECHO_REPLY_CLASSIFIER_CORE_ASSERT_SVH
`define ICMP_ECHO_REPLY_CLASSIFIER_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define ICMPERC_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define ICMPERC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/icmperc_pkg.sv @@
// Shared types and constants for the ICMP echo reply classifier.
package icmperc_pkg;

   localparam int MAX_PACKET = 2048;
   localparam int POS_W      = $clog2(MAX_PACKET + 1);

   typedef logic [POS_W-1:0] pos_type;

   // Register indexes
   localparam logic CSR_EXPECTED_ID  = 1'b0;
   localparam logic CSR_EXPECTED_SEQ = 1'b1;

   // Verdict codes
   localparam logic [1:0] VERDICT_NO_MATCH  = 2'd0;
   localparam logic [1:0] VERDICT_ECHO      = 2'd1;
   localparam logic [1:0] VERDICT_TIME_EXCD = 2'd2;

   // ICMP types and IP header fields
   localparam logic [7:0] ICMP_ECHO_REPLY = 8'd0;
   localparam logic [7:0] ICMP_TIME_EXCD  = 8'd11;
   localparam logic [3:0] IP_VERSION_4    = 4'h4;
   localparam int         TTL_OFFSET      = 8;

   typedef struct packed {
      logic [7:0] pkt_byte;
      logic       last_byte;
   } byte_type;

   typedef struct packed {
      logic [7:0] hop_ttl;
      logic [1:0] verdict;
   } result_type;

endpackage

@@ hdl/icmperc_parse.sv @@
// Per-packet header parser: captures header fields byte by byte and forms the verdict.
module icmperc_parse (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    byte_valid,
   input  icmperc_pkg::byte_type   byte_in,
   input  logic [15:0]             expected_id,
   input  logic [15:0]             expected_seq,
   output icmperc_pkg::result_type result
);
   import icmperc_pkg::*;

   pos_type     pos_ff,    pos_in;
   logic [5:0]  hlen_ff,   hlen_in;
   logic        v4_ff,     v4_in;
   logic [7:0]  ttl_ff,    ttl_in;
   logic [7:0]  type_ff,   type_in;
   logic [5:0]  ilen_ff,   ilen_in;
   logic [15:0] rid_ff,    rid_in;
   logic [15:0] rseq_ff,   rseq_in;
   logic [15:0] qid_ff,    qid_in;
   logic [15:0] qseq_ff,   qseq_in;

   logic       live;
   logic [7:0] b;
   pos_type    hpos, qpos;

   always_comb begin
      b    = byte_in.pkt_byte;
      live = byte_valid && (pos_ff < pos_type'(MAX_PACKET));

      pos_in  = pos_ff;
      hlen_in = hlen_ff;
      v4_in   = v4_ff;
      ttl_in  = ttl_ff;
      type_in = type_ff;
      ilen_in = ilen_ff;
      rid_in  = rid_ff;
      rseq_in = rseq_ff;
      qid_in  = qid_ff;
      qseq_in = qseq_ff;

      if (live) begin
         pos_in = pos_ff + pos_type'(1);
         if (pos_ff == '0) begin
            v4_in   = (b[7:4] == IP_VERSION_4);
            hlen_in = {b[3:0], 2'b00};
         end
         if (pos_ff == pos_type'(TTL_OFFSET)) ttl_in = b;
      end

      // Offsets use the header length as updated by this very byte.
      hpos = pos_type'(hlen_in);
      if (live) begin
         if (pos_ff == hpos) type_in = b;
         if (pos_ff == hpos + pos_type'(4)) rid_in[15:8]  = b;
         if (pos_ff == hpos + pos_type'(5)) rid_in[7:0]   = b;
         if (pos_ff == hpos + pos_type'(6)) rseq_in[15:8] = b;
         if (pos_ff == hpos + pos_type'(7)) rseq_in[7:0]  = b;
         if (pos_ff == hpos + pos_type'(8))
            ilen_in = (b[7:4] == IP_VERSION_4) ? {b[3:0], 2'b00} : 6'd0;
      end

      qpos = hpos + pos_type'(8) + pos_type'(ilen_in);
      if (live) begin
         if (pos_ff == qpos + pos_type'(4)) qid_in[15:8]  = b;
         if (pos_ff == qpos + pos_type'(5)) qid_in[7:0]   = b;
         if (pos_ff == qpos + pos_type'(6)) qseq_in[15:8] = b;
         if (pos_ff == qpos + pos_type'(7)) qseq_in[7:0]  = b;
      end

      result.verdict = VERDICT_NO_MATCH;
      result.hop_ttl = 8'd0;
      if (v4_in) begin
         if (type_in == ICMP_TIME_EXCD) begin
            if (qid_in == expected_id && qseq_in == expected_seq)
               result.verdict = VERDICT_TIME_EXCD;
         end else if (type_in == ICMP_ECHO_REPLY) begin
            if (rid_in == expected_id && rseq_in == expected_seq) begin
               result.verdict = VERDICT_ECHO;
               result.hop_ttl = ttl_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (byte_valid && byte_in.last_byte)) begin
         pos_ff  <= '0;
         hlen_ff <= '0;
         v4_ff   <= 1'b0;
         ttl_ff  <= '0;
         type_ff <= '0;
         ilen_ff <= '0;
         rid_ff  <= '0;
         rseq_ff <= '0;
         qid_ff  <= '0;
         qseq_ff <= '0;
      end else begin
         pos_ff  <= pos_in;
         hlen_ff <= hlen_in;
         v4_ff   <= v4_in;
         ttl_ff  <= ttl_in;
         type_ff <= type_in;
         ilen_ff <= ilen_in;
         rid_ff  <= rid_in;
         rseq_ff <= rseq_in;
         qid_ff  <= qid_in;
         qseq_ff <= qseq_in;
      end
   end

endmodule

@@ hdl/icmp_echo_reply_classifier_core.sv @@
// Top level of the ICMP echo reply classifier: stream ports, input and result registers.
//
//   channel | dir | payload                              | transfer when
//   req_    | in  | tdata[7:0] pkt_byte, tlast last_byte | req_tvalid & req_tready
//   rsp_    | out | tdata[1:0] verdict, [9:2] hop_ttl    | rsp_tvalid & rsp_tready
//   csr_    | in  | index 0 expected_id, 1 expected_seq  | csr_wr_en
//
// One byte per clock sustained while no last byte waits on a stalled result.
// A byte is held in the input register, then the parser updates its captured
// fields; on the last byte the verdict is loaded into the result register,
// which drives rsp_tvalid until the verdict is taken.
// Reset is synchronous and clears all control and captured header state.
// A stalled result only holds up a last byte; other bytes keep flowing, and the
// input register refills in the cycle the result is taken.
module icmp_echo_reply_classifier_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] pkt_byte
   input  logic        req_tlast,   // last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [1:0] verdict, [9:2] hop_ttl, [15:10] zero
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);
   import icmperc_pkg::*;

   // Match registers
   logic [15:0] exp_id_ff, exp_seq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_id_ff  <= '0;
         exp_seq_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_EXPECTED_ID:  exp_id_ff  <= csr_wdata;
            CSR_EXPECTED_SEQ: exp_seq_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Input register
   logic     s1_valid_ff, s1_valid_in;
   byte_type s1_byte_ff;
   logic     out_free, advance;

   // Result register
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_data_ff;
   result_type result;

   assign out_free = !rsp_valid_ff || rsp_tready;
   // A non-final byte never needs the result register.
   assign advance     = s1_valid_ff && (!s1_byte_ff.last_byte || out_free);
   assign req_tready  = !s1_valid_ff || advance;
   assign s1_valid_in = (req_tvalid && req_tready) || (s1_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) s1_valid_ff <= 1'b0;
      else       s1_valid_ff <= s1_valid_in;
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_byte_ff.pkt_byte  <= req_tdata;
         s1_byte_ff.last_byte <= req_tlast;
      end
   end

   icmperc_parse u_parse (
      .clock        (clock),
      .reset        (reset),
      .byte_valid   (advance),
      .byte_in      (s1_byte_ff),
      .expected_id  (exp_id_ff),
      .expected_seq (exp_seq_ff),
      .result       (result)
   );

   logic load_rsp;
   assign load_rsp     = advance && s1_byte_ff.last_byte;
   assign rsp_valid_in = load_rsp || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (load_rsp) rsp_data_ff <= result;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_data_ff.hop_ttl, rsp_data_ff.verdict};

`include "icmp_echo_reply_classifier_core_assert.svh"

   `ICMPERC_ASSERT_NEXT(a_last_gives_result, clock, reset, load_rsp, rsp_valid_ff,
      "last byte did not produce a result")
   `ICMPERC_ASSERT_IMPL(a_verdict_code, clock, reset, rsp_valid_ff,
      rsp_data_ff.verdict <= VERDICT_TIME_EXCD, "undefined verdict code")
   `ICMPERC_ASSERT_IMPL(a_ttl_only_echo, clock, reset,
      rsp_valid_ff && rsp_data_ff.verdict != VERDICT_ECHO, rsp_data_ff.hop_ttl == 8'd0,
      "hop_ttl set without an echo match")
   `ICMPERC_ASSERT_IMPL(a_stall_needs_byte, clock, reset, !req_tready,
      s1_valid_ff && s1_byte_ff.last_byte && rsp_valid_ff,
      "input stalled without a pending last byte")

endmodule
